FILE: rtl/core/ir_pulse_train_packetizer_assert.svh
// assertion macros for the ir pulse train packetizer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef IR_PULSE_TRAIN_PACKETIZER_ASSERT_SVH
`define IR_PULSE_TRAIN_PACKETIZER_ASSERT_SVH

// same-cycle implication
`define IRPTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRPTP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/irptp_pkg.sv
// shared constants and types of the ir pulse train packetizer
// no dependencies
package irptp_pkg;

    localparam int PACKET_BYTES_DEF = 64;

    localparam int CARRIER_W = 17;
    localparam int DUR_W     = 24;
    localparam int BYTE_W    = 8;
    localparam int HP_W      = 7;
    localparam int DIV_W     = 22;
    localparam int QUO_W     = 15;
    localparam int CNT_W     = 4;

    localparam logic [BYTE_W-1:0]    CMD_IR_DATA     = 8'h01;
    localparam logic [15:0]          DEFAULT_CARRIER = 16'd38000;
    localparam logic [15:0]          MIN_CARRIER     = 16'd30000;
    localparam logic [15:0]          MAX_CARRIER     = 16'd42000;
    localparam logic [DIV_W-1:0]     HALF_PERIOD_NUM = 22'd3000000;
    localparam logic [DUR_W-1:0]     COMMAND_THRESHOLD = 24'h007500;
    // 13 * 0x8000, at or above this the command quotient saturates
    localparam logic [DUR_W-1:0]     CMD_SAT_LIMIT   = 24'd425984;
    // ceil(2^23 / 13), gives floor(d / 13) exactly for d below 2^19
    localparam logic [19:0]          CMD_RECIP       = 20'd645278;
    localparam int                   CMD_RECIP_SHIFT = 23;
    localparam logic [QUO_W-1:0]     WORD_MAX        = 15'h7FFF;

    // quotient bits minus one for each division kind
    localparam logic [CNT_W-1:0]     HP_STEPS_M1   = 4'd6;
    localparam logic [CNT_W-1:0]     DATA_STEPS_M1 = 4'd11;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             final_item;
    } dur_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_end;
        logic              run_last;
    } pkt_word_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] dsor;
        logic [CNT_W-1:0] steps_m1;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: rtl/core/irptp_if.sv
// valid/ready channel interfaces: duration input, packet byte output, carrier write
// depends on irptp_pkg
interface irptp_dur_if import irptp_pkg::*; ();
    logic      valid;
    logic      ready;
    dur_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irptp_pkt_if import irptp_pkg::*; ();
    logic      valid;
    logic      ready;
    pkt_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irptp_cfg_if import irptp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CARRIER_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ir_pulse_train_packetizer.sv
// top level of the ir pulse train packetizer: carrier register, sequencer, divider
// depends on irptp_pkg, irptp_if, irptp_divider, irptp_seq
//
//  channel    role   word                               accepted when
//  dur_chan   sink   duration[23:0], final_item         valid && ready
//  pkt_chan   source out_byte[7:0], packet_end, run_last valid && ready
//  cfg_chan   sink   carrier_hz[16:0]                   valid && ready (ready tied high)
//
// one duration at a time; the shared divider sets the pace, one quotient bit a cycle
// data word: a divider pass (12 divider steps), then its n bytes; command word (reciprocal multiply)
// and saturated word: no divider pass, only the n bytes; n is the byte count of the item (2..PACKET_BYTES)
// packet start adds the half-period division (7 steps)
// asynchronous active-low reset clears control state only; no clearing pass
// a stall on pkt_chan freezes emission; the held byte does not block the next duration

module ir_pulse_train_packetizer import irptp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    irptp_dur_if.sink    dur_chan,
    irptp_pkt_if.source  pkt_chan,
    irptp_cfg_if.sink    cfg_chan
);

    // carrier register, written any time, sampled at packet start
    logic [CARRIER_W-1:0] carrier_reg, carrier_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_chan.ready = 1'b1;

    always_comb
    begin
        carrier_next = carrier_reg;
        if (cfg_chan.valid)
            carrier_next = cfg_chan.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carrier_reg <= '0;
        else
            carrier_reg <= carrier_next;
    end

    // sequencer: header, word and padding bytes, output register
    irptp_seq #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .carrier_hz (carrier_reg),
        .dur_chan   (dur_chan),
        .pkt_chan   (pkt_chan),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    // one divider shared by the half-period and data word divisions
    irptp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

FILE: rtl/core/irptp_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on irptp_pkg
module irptp_divider import irptp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsor_reg, dsor_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = (rem_reg >= dsor_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            dsor_next = req.dsor;
            quo_next  = '0;
            cnt_next  = req.steps_m1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_reg - dsor_reg) : rem_reg;
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            dsor_next = dsor_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: rtl/core/irptp_seq.sv
// sequencer: takes a duration, drives the shared divider, emits packet bytes
// depends on irptp_pkg, irptp_if
module irptp_seq import irptp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CARRIER_W-1:0] carrier_hz,
    irptp_dur_if.sink            dur_chan,
    irptp_pkt_if.source          pkt_chan,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam int CMP_W = POS_W + 2;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);
    localparam logic [CMP_W-1:0] PKT_LEN  = CMP_W'(PACKET_BYTES);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HP     = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WORD   = 5'b01000,
        S_EMIT   = 5'b10000
    } seq_state_t;

    typedef enum logic [4:0] {
        PH_CMD = 5'b00001,
        PH_HP  = 5'b00010,
        PH_HI  = 5'b00100,
        PH_LO  = 5'b01000,
        PH_PAD = 5'b10000
    } phase_t;

    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              parity_reg, parity_next;
    logic [HP_W-1:0]   hp_reg, hp_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic              final_reg, final_next;
    logic              hdr_reg, hdr_next;
    logic [QUO_W-1:0]  word_reg, word_next;
    pkt_word_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [15:0]       carrier_clamped;
    logic              accept;
    logic              can_load;
    logic              is_cmd;
    logic              cmd_sat;
    logic              need_div;
    logic [17:0]       dur6;
    logic [38:0]       cmd_prod;
    logic [QUO_W-1:0]  cmd_quo;
    logic              end_b;
    logic              pad_need;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    phase_t            emit_phase;
    phase_t            first_phase;

    // zero means default, then clamp to the legal carrier range
    always_comb
    begin
        if (carrier_hz == '0)
            carrier_clamped = DEFAULT_CARRIER;
        else if (carrier_hz < {1'b0, MIN_CARRIER})
            carrier_clamped = MIN_CARRIER;
        else if (carrier_hz > {1'b0, MAX_CARRIER})
            carrier_clamped = MAX_CARRIER;
        else
            carrier_clamped = carrier_hz[15:0];
    end

    assign dur_chan.ready = (state_reg == S_IDLE);
    assign accept         = dur_chan.valid && dur_chan.ready;
    assign can_load       = !out_valid_reg || pkt_chan.ready;

    assign is_cmd   = (dur_reg >= COMMAND_THRESHOLD);
    assign cmd_sat  = (dur_reg >= CMD_SAT_LIMIT);
    assign need_div = !is_cmd && (hp_reg != '0);
    // data durations stay below 0x7500, so 6*d fits 18 bits
    assign dur6 = {1'b0, dur_reg[14:0], 2'b00} + {2'b00, dur_reg[14:0], 1'b0};
    // unsaturated command values stay below 2^19, divide by 13 through the reciprocal
    assign cmd_prod = dur_reg[18:0] * CMD_RECIP;
    assign cmd_quo  = QUO_W'(cmd_prod >> CMD_RECIP_SHIFT);

    assign first_phase = hdr_reg ? PH_CMD : PH_HI;

    always_comb
    begin
        div_req = '0;
        if (state_reg == S_IDLE && accept && pos_reg == '0)
        begin
            div_req.start    = 1'b1;
            div_req.num      = HALF_PERIOD_NUM;
            div_req.dsor     = {carrier_clamped, 6'b000000};
            div_req.steps_m1 = HP_STEPS_M1;
        end
        else if (state_reg == S_LAUNCH && need_div)
        begin
            div_req.start    = 1'b1;
            div_req.num      = {4'b0000, dur6};
            div_req.dsor     = {4'b0000, hp_reg, 11'b0};
            div_req.steps_m1 = DATA_STEPS_M1;
        end
    end

    // byte selection for the current emit phase
    assign end_b    = (pos_reg == POS_LAST);
    assign pad_need = !end_b && (final_reg || (({2'b00, pos_reg} + CMP_W'(3)) > PKT_LEN));

    always_comb
    begin
        emit_byte  = '0;
        emit_last  = 1'b0;
        emit_phase = phase_reg;
        case (phase_reg)
            PH_CMD:
            begin
                emit_byte  = CMD_IR_DATA;
                emit_phase = PH_HP;
            end
            PH_HP:
            begin
                emit_byte  = {1'b0, hp_reg};
                emit_phase = PH_HI;
            end
            PH_HI:
            begin
                emit_byte  = {~parity_reg, word_reg[14:8]};
                emit_phase = PH_LO;
            end
            PH_LO:
            begin
                emit_byte  = word_reg[7:0];
                emit_last  = !pad_need;
                emit_phase = PH_PAD;
            end
            PH_PAD:
            begin
                emit_byte  = '0;
                emit_last  = end_b;
            end
            default:
            begin
                emit_byte  = '0;
                emit_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        parity_next    = parity_reg;
        hp_next        = hp_reg;
        dur_next       = dur_reg;
        final_next     = final_reg;
        hdr_next       = hdr_reg;
        word_next      = word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pkt_chan.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dur_next   = dur_chan.data.duration;
                    final_next = dur_chan.data.final_item;
                    hdr_next   = (pos_reg == '0);
                    state_next = (pos_reg == '0) ? S_HP : S_LAUNCH;
                end
            end
            S_HP:
            begin
                if (div_rsp.done)
                begin
                    hp_next    = div_rsp.quo[HP_W-1:0];
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                if (need_div)
                    state_next = S_WORD;
                else
                begin
                    word_next  = (is_cmd && !cmd_sat) ? cmd_quo : WORD_MAX;
                    phase_next = first_phase;
                    state_next = S_EMIT;
                end
            end
            S_WORD:
            begin
                if (div_rsp.done)
                begin
                    word_next  = div_rsp.quo;
                    phase_next = first_phase;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_next.out_byte   = emit_byte;
                    out_next.packet_end = end_b;
                    out_next.run_last   = emit_last;
                    out_valid_next      = 1'b1;
                    pos_next            = end_b ? '0 : pos_reg + 1'b1;
                    phase_next          = emit_phase;
                    if (emit_last)
                    begin
                        parity_next = final_reg ? 1'b0 : ~parity_reg;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CMD;
            pos_reg       <= '0;
            parity_reg    <= 1'b0;
            hp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            parity_reg    <= parity_next;
            hp_reg        <= hp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg   <= dur_next;
        final_reg <= final_next;
        hdr_reg   <= hdr_next;
        word_reg  <= word_next;
        out_reg   <= out_next;
    end

    assign pkt_chan.valid = out_valid_reg;
    assign pkt_chan.data  = out_reg;

endmodule

FILE: rtl/core/irptp_checker.sv
// port-level checks of the ir pulse train packetizer, attached by bind
// depends on irptp_pkg, ir_pulse_train_packetizer_assert.svh
`include "ir_pulse_train_packetizer_assert.svh"

module irptp_checker import irptp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      dur_valid,
    input logic      dur_ready,
    input logic      pkt_valid,
    input logic      pkt_ready,
    input pkt_word_t pkt_data
);

    // a stalled byte holds
    `IRPTP_ASSERT_NXT(a_pkt_hold, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt_data), "stalled byte changed")

    // one duration at a time
    `IRPTP_ASSERT_NXT(a_one_item, dur_valid && dur_ready, !dur_ready, "duration taken while busy")

    // a byte that is not the last of its item means the item is still in flight
    `IRPTP_ASSERT_IMP(a_mid_item, pkt_valid && !pkt_data.run_last, !dur_ready, "ready in mid item")

    // the word needs work before its first byte
    `IRPTP_ASSERT_NXT(a_no_early, dur_valid && dur_ready, !$rose(pkt_valid), "byte too early")

endmodule

bind ir_pulse_train_packetizer irptp_checker u_irptp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dur_valid (dur_chan.valid),
    .dur_ready (dur_chan.ready),
    .pkt_valid (pkt_chan.valid),
    .pkt_ready (pkt_chan.ready),
    .pkt_data  (pkt_chan.data)
);
